>>> rtl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// Used by every module under rtl; depends on nothing else.
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ALU_W    = POS_W + 2;

    typedef enum logic [2:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_DEL_HEAD = 3'd3,
        ACT_DEL_TAIL = 3'd4,
        ACT_DEL_VAL  = 3'd5,
        ACT_DEL_POS  = 3'd6,
        ACT_READ     = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_CHK,
        S_UP_WR,
        S_PUT,
        S_DN_CHK,
        S_DN_WR,
        S_DN_END,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_OUT_RD,
        S_OUT_EMIT,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        ALU_NONE,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        act_t                     action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        stat_t                    status;
        logic signed [DATA_W-1:0] element;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> rtl/ole_alu.sv
// Shared index step and compare unit of the ordered list engine.
// Depends on ole_pkg.
module ole_alu (
    input  logic [ole_pkg::ALU_W-1:0]  a,
    input  logic [ole_pkg::ALU_W-1:0]  b,
    input  ole_pkg::alu_op_t           op,
    input  logic [ole_pkg::DATA_W-1:0] x,
    input  logic [ole_pkg::DATA_W-1:0] y,
    output logic [ole_pkg::ALU_W-1:0]  sum,
    output logic                       lt,
    output logic                       eq
);
    import ole_pkg::*;

    always_comb
    begin
        case (op)
            ALU_INC:  sum = a + ALU_W'(1);
            ALU_DEC:  sum = a - ALU_W'(1);
            ALU_NONE: sum = a;
            default:  sum = a;
        endcase
    end

    assign lt = $signed(sum) < $signed(b);
    assign eq = (x == y);

endmodule

>>> rtl/ole_mem.sv
// Entry storage of the ordered list engine: one write port, one registered read port.
// Depends on ole_pkg.
module ole_mem (
    input  logic                       clk,
    input  ole_pkg::mem_req_t          mem_req,
    output logic [ole_pkg::DATA_W-1:0] rd_data
);
    import ole_pkg::*;

    logic [DATA_W-1:0] entries_reg [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            entries_reg[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= entries_reg[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ole_ctrl.sv
// Sequencer of the ordered list engine: decodes a request, steps the shared
// index unit over the entry memory and issues results. Depends on ole_pkg, ole_alu.
module ole_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ole_pkg::req_t              req,
    input  logic                       out_free,
    output logic                       emit,
    output ole_pkg::res_t              res,
    output ole_pkg::mem_req_t          mem_req,
    input  logic [ole_pkg::DATA_W-1:0] rd_data
);
    import ole_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    act_t              act_reg, act_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] tgt_reg, tgt_next;
    stat_t             stat_reg, stat_next;

    logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
    alu_op_t           alu_op;
    logic              alu_lt, alu_eq;

    stat_t             dec_stat;
    logic              full, empty, pos_zero;
    logic [POS_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  cnt_m1;

    ole_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .op  (alu_op),
        .x   (rd_data),
        .y   (val_reg),
        .sum (alu_sum),
        .lt  (alu_lt),
        .eq  (alu_eq)
    );

    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign pos_zero = (pos_reg == '0);
    assign pos_m1   = pos_reg - POS_W'(1);
    assign cnt_m1   = cnt_reg - CNT_W'(1);

    always_comb
    begin
        dec_stat = STAT_OK;
        case (act_reg)
            ACT_INS_HEAD, ACT_INS_TAIL:
            begin
                if (full)
                    dec_stat = STAT_FULL;
            end
            ACT_INS_POS:
            begin
                if (pos_zero || alu_lt)
                    dec_stat = STAT_BADPOS;
                else if (full)
                    dec_stat = STAT_FULL;
            end
            ACT_DEL_POS:
            begin
                if (empty)
                    dec_stat = STAT_EMPTY;
                else if (pos_zero || alu_lt)
                    dec_stat = STAT_BADPOS;
            end
            default:
            begin
                if (empty)
                    dec_stat = STAT_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (dec_stat != STAT_OK)
                    state_next = S_RESULT;
                else
                begin
                    case (act_reg)
                        ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: state_next = S_UP_CHK;
                        ACT_DEL_VAL: state_next = S_SRCH_RD;
                        ACT_READ:    state_next = S_OUT_RD;
                        default:     state_next = S_DN_CHK;
                    endcase
                end
            end
            S_UP_CHK:   state_next = alu_lt ? S_PUT : S_UP_WR;
            S_UP_WR:    state_next = S_UP_CHK;
            S_PUT:      state_next = S_RESULT;
            S_DN_CHK:   state_next = alu_lt ? S_DN_WR : S_DN_END;
            S_DN_WR:    state_next = S_DN_CHK;
            S_DN_END:   state_next = S_RESULT;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (alu_eq)
                    state_next = S_DN_CHK;
                else if (alu_lt)
                    state_next = S_SRCH_RD;
                else
                    state_next = S_RESULT;
            end
            S_OUT_RD:   state_next = S_OUT_EMIT;
            S_OUT_EMIT:
            begin
                if (out_free)
                    state_next = alu_lt ? S_OUT_RD : S_IDLE;
            end
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        emit          = 1'b0;
        res.status    = stat_reg;
        res.element   = '0;
        res.count     = cnt_reg;
        res.last      = 1'b1;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = rd_data;
        mem_req.re    = 1'b0;
        mem_req.raddr = idx_reg;
        alu_a         = ALU_W'(idx_reg);
        alu_b         = ALU_W'(cnt_reg);
        alu_op        = ALU_NONE;
        cnt_next      = cnt_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        stat_next     = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act_next = req.action;
                    val_next = req.value;
                    pos_next = req.position;
                end
            end
            S_DECIDE:
            begin
                alu_a     = ALU_W'(cnt_reg);
                alu_b     = ALU_W'(pos_reg);
                alu_op    = (act_reg == ACT_INS_POS) ? ALU_INC : ALU_NONE;
                stat_next = dec_stat;
                case (act_reg)
                    ACT_INS_HEAD:
                    begin
                        tgt_next = '0;
                        idx_next = cnt_reg[ADDR_W-1:0];
                    end
                    ACT_INS_TAIL:
                    begin
                        tgt_next = cnt_reg[ADDR_W-1:0];
                        idx_next = cnt_reg[ADDR_W-1:0];
                    end
                    ACT_INS_POS:
                    begin
                        tgt_next = pos_m1[ADDR_W-1:0];
                        idx_next = cnt_reg[ADDR_W-1:0];
                    end
                    ACT_DEL_TAIL: idx_next = cnt_m1[ADDR_W-1:0];
                    ACT_DEL_POS:  idx_next = pos_m1[ADDR_W-1:0];
                    default:      idx_next = '0;
                endcase
            end
            S_UP_CHK:
            begin
                alu_b         = ALU_W'(tgt_reg);
                alu_op        = ALU_DEC;
                mem_req.re    = !alu_lt;
                mem_req.raddr = alu_sum[ADDR_W-1:0];
            end
            S_UP_WR:
            begin
                mem_req.we = 1'b1;
                alu_op     = ALU_DEC;
                idx_next   = alu_sum[ADDR_W-1:0];
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = val_reg;
                cnt_next      = cnt_reg + CNT_W'(1);
            end
            S_DN_CHK:
            begin
                alu_op        = ALU_INC;
                mem_req.re    = alu_lt;
                mem_req.raddr = alu_sum[ADDR_W-1:0];
            end
            S_DN_WR:
            begin
                mem_req.we = 1'b1;
                alu_op     = ALU_INC;
                idx_next   = alu_sum[ADDR_W-1:0];
            end
            S_DN_END:
            begin
                cnt_next  = cnt_m1;
                stat_next = STAT_OK;
            end
            S_SRCH_RD:
            begin
                mem_req.re = 1'b1;
            end
            S_SRCH_CMP:
            begin
                alu_op = ALU_INC;
                if (!alu_eq)
                begin
                    if (alu_lt)
                        idx_next = alu_sum[ADDR_W-1:0];
                    else
                        stat_next = STAT_NOTFOUND;
                end
            end
            S_OUT_RD:
            begin
                mem_req.re = 1'b1;
            end
            S_OUT_EMIT:
            begin
                alu_op      = ALU_INC;
                emit        = out_free;
                res.status  = STAT_OK;
                res.element = rd_data;
                res.last    = !alu_lt;
                if (out_free)
                    idx_next = alu_sum[ADDR_W-1:0];
            end
            S_RESULT:
            begin
                emit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        tgt_reg  <= tgt_next;
        stat_reg <= stat_next;
    end

endmodule

>>> rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: sequencer, entry memory and result register.
// Depends on ole_pkg, ole_ctrl, ole_mem.
//
// Holds an ordered list of up to 16 signed 32-bit entries in a single-port-write,
// registered-read memory, and takes one request at a time. Every step goes through
// one memory access and one shared index/compare unit, so the cost follows the
// number of entries touched: an insert grows with the number of entries moved back,
// a delete at a position with the entries moved forward, and a delete by value
// also with the entries inspected; read out grows with the entries emitted, and a
// request rejected by a status check goes straight to its result. Results pass
// through an output register, so a request can be accepted while the last result
// still waits to be taken. No clearing is needed after reset.
module ordered_list_engine_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ole_pkg::req_t  req,
    output logic           res_valid,
    input  logic           res_ready,
    output ole_pkg::res_t  res
);
    import ole_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    logic              emit;
    logic              out_free;
    res_t              emit_res;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_free  (out_free),
        .emit      (emit),
        .res       (emit_res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    ole_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign out_free = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= emit_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
